// ===== sv/bgi_pkg.sv =====
`default_nettype none

package bgi_pkg;

    // Field and register widths
    localparam int Q_W         = 32;   // Q16.16 word
    localparam int STEP_W      = 31;   // grid spacing
    localparam int CNT_W       = 6;    // grid point count
    localparam int IDX_IN_W    = 5;    // write column/row index
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Datapath widths
    localparam int U_W         = Q_W + 1;          // coordinate plus offset
    localparam int PROD_W      = Q_W + STEP_W;     // |delta| * remainder
    localparam int QUO_W       = 32;               // quotient bits per division
    localparam int DIV_CNT_W   = $clog2(QUO_W + 1);
    localparam int LERP_W      = Q_W + 2;          // base + signed quotient

    // Corner fetch
    localparam int CORNER_W    = 2;
    localparam int NUM_CORNERS = 4;
    localparam int FETCH_CNT_W = 3;

    // Register reset values
    localparam logic [Q_W-1:0]    OFFSET_RESET = '0;
    localparam logic [STEP_W-1:0] STEP_RESET   = 31'd65536;
    localparam logic [CNT_W-1:0]  COUNT_RESET  = 6'd32;

    // Saturation limits
    localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

    // Input operation codes
    localparam logic OPER_WRITE = 1'b0;
    localparam logic OPER_QUERY = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_OFFSET = 3'd0,
        CFG_X_STEP   = 3'd1,
        CFG_X_COUNT  = 3'd2,
        CFG_Y_OFFSET = 3'd3,
        CFG_Y_STEP   = 3'd4,
        CFG_Y_COUNT  = 3'd5
    } cfg_reg_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_WRITE,
        OP_DIV_IDX,
        OP_IDX_LATCH,
        OP_DIFF_X,
        OP_MUL_X,
        OP_DIV_X,
        OP_LERP_X,
        OP_DIFF_Y,
        OP_MUL_Y,
        OP_DIV_Y,
        OP_LERP_Y,
        OP_OUT_VAL,
        OP_OUT_OOR
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WAIT_IDX,
        ST_IDX,
        ST_FETCH,
        ST_DIFF_X,
        ST_MUL_X,
        ST_START_X,
        ST_WAIT_X,
        ST_LERP_X,
        ST_DIFF_Y,
        ST_MUL_Y,
        ST_START_Y,
        ST_WAIT_Y,
        ST_LERP_Y,
        ST_OUT_VAL,
        ST_OUT_OOR
    } ctl_state_t;

    typedef struct packed {
        dp_op_t              op;
        logic                rd_en;
        logic [CORNER_W-1:0] rd_corner;
        logic                cap_en;
        logic [CORNER_W-1:0] cap_corner;
    } dp_cmd_t;

    typedef struct packed {
        logic pre_ok;    // both axes pass sign, step and count checks
        logic idx_ok;    // both cell indexes leave room for the upper neighbor
        logic div_done;  // divider pass finished
    } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/bgi_if.sv =====
`default_nettype none

// Input word channel
interface bgi_item_if;
    import bgi_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic signed [Q_W-1:0]      x_value;
    logic signed [Q_W-1:0]      y_value;
    logic        [IDX_IN_W-1:0] col_index;
    logic        [IDX_IN_W-1:0] row_index;
    logic signed [Q_W-1:0]      entry_value;

    modport source (
        output valid, operation, x_value, y_value, col_index, row_index, entry_value,
        input  ready
    );

    modport sink (
        input  valid, operation, x_value, y_value, col_index, row_index, entry_value,
        output ready
    );
endinterface

// Result word channel
interface bgi_result_if;
    import bgi_pkg::*;

    logic                  valid;
    logic                  ready;
    logic signed [Q_W-1:0] result_value;
    logic                  out_of_range;

    modport source (
        output valid, result_value, out_of_range,
        input  ready
    );

    modport sink (
        input  valid, result_value, out_of_range,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/bgi_div.sv =====
`default_nettype none

// Radix-2 restoring divider, one quotient bit per cycle.
// Expects dividend >> QUO_W to be below the divisor, so the quotient fits QUO_W bits.
module bgi_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [bgi_pkg::PROD_W-1:0]    dividend,
    input  wire logic [bgi_pkg::STEP_W-1:0]    divisor,
    output logic      [bgi_pkg::QUO_W-1:0]     quotient,
    output logic      [bgi_pkg::STEP_W-1:0]    remainder,
    output logic                               done
);
    import bgi_pkg::*;

    logic [STEP_W-1:0]    rem_reg, rem_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [STEP_W-1:0]    dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [STEP_W:0]      trial;
    logic [STEP_W+1:0]    diff;
    logic                 ge;

    // One trial subtraction per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[QUO_W-1]};
        diff  = {1'b0, trial} - {2'b00, dsr_reg};
        ge    = ~diff[STEP_W+1];
    end

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend[PROD_W-1:QUO_W];
            quo_next  = dividend[QUO_W-1:0];
            dsr_next  = divisor;
            cnt_next  = DIV_CNT_W'(QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], ge};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operands
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

    // A pass is never restarted while running
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    // Last iteration ends the pass with a done pulse
    a_last_iter: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start && cnt_reg == DIV_CNT_W'(1) |=> done_reg && !busy_reg)
        else $error("divider did not finish after last iteration");

    // Done only follows a running pass
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a pass");

endmodule

`default_nettype wire

// ===== sv/bgi_datapath.sv =====
`default_nettype none

module bgi_datapath #(
    parameter int unsigned MAX_X_POINTS = 32,
    parameter int unsigned MAX_Y_POINTS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire bgi_pkg::dp_cmd_t                   cmd,
    output bgi_pkg::dp_status_t                     status,
    // configuration
    input  wire logic                               cfg_wr_en,
    input  wire logic [bgi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bgi_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input word payload
    input  wire logic [bgi_pkg::Q_W-1:0]            x_value,
    input  wire logic [bgi_pkg::Q_W-1:0]            y_value,
    input  wire logic [bgi_pkg::IDX_IN_W-1:0]       col_index,
    input  wire logic [bgi_pkg::IDX_IN_W-1:0]       row_index,
    input  wire logic [bgi_pkg::Q_W-1:0]            entry_value,
    // result word payload
    output logic      [bgi_pkg::Q_W-1:0]            result_value,
    output logic                                    out_of_range
);
    import bgi_pkg::*;

    localparam int XW        = $clog2(MAX_X_POINTS);
    localparam int YW        = $clog2(MAX_Y_POINTS);
    localparam int XCW       = $clog2(MAX_X_POINTS + 1);
    localparam int YCW       = $clog2(MAX_Y_POINTS + 1);
    localparam int AW        = XW + YW;
    localparam int MEM_DEPTH = 1 << AW;

    // Configuration registers
    logic [Q_W-1:0]    x_off_reg, y_off_reg;
    logic [STEP_W-1:0] x_step_reg, y_step_reg;
    logic [CNT_W-1:0]  x_count_reg, y_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_off_reg   <= OFFSET_RESET;
            x_step_reg  <= STEP_RESET;
            x_count_reg <= COUNT_RESET;
            y_off_reg   <= OFFSET_RESET;
            y_step_reg  <= STEP_RESET;
            y_count_reg <= COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_X_OFFSET: x_off_reg   <= cfg_data;
                CFG_X_STEP:   x_step_reg  <= cfg_data[STEP_W-1:0];
                CFG_X_COUNT:  x_count_reg <= cfg_data[CNT_W-1:0];
                CFG_Y_OFFSET: y_off_reg   <= cfg_data;
                CFG_Y_STEP:   y_step_reg  <= cfg_data[STEP_W-1:0];
                CFG_Y_COUNT:  y_count_reg <= cfg_data[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Counts clamped to the store size
    logic [XCW-1:0] x_cnt_eff;
    logic [YCW-1:0] y_cnt_eff;

    always_comb
    begin
        if (32'(x_count_reg) > MAX_X_POINTS)
            x_cnt_eff = XCW'(MAX_X_POINTS);
        else
            x_cnt_eff = XCW'(x_count_reg);
        if (32'(y_count_reg) > MAX_Y_POINTS)
            y_cnt_eff = YCW'(MAX_Y_POINTS);
        else
            y_cnt_eff = YCW'(y_count_reg);
    end

    // Grid store, row-major with column in the low address bits
    logic [Q_W-1:0] grid_mem [MEM_DEPTH];
    logic [Q_W-1:0] rd_data_reg;
    logic [AW-1:0]  wr_addr, rd_addr;
    logic           wr_ok;
    logic [XW-1:0]  ix_reg;
    logic [YW-1:0]  iy_reg;

    assign wr_ok   = (32'(col_index) < MAX_X_POINTS) && (32'(row_index) < MAX_Y_POINTS);
    assign wr_addr = {YW'(row_index), XW'(col_index)};
    assign rd_addr = {iy_reg + YW'(cmd.rd_corner[1]), ix_reg + XW'(cmd.rd_corner[0])};

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_WRITE && wr_ok)
            grid_mem[wr_addr] <= entry_value;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rd_data_reg <= grid_mem[rd_addr];
    end

    // Shared dividers: index pass, row interpolation pass, column pass
    logic              div_start;
    logic [PROD_W-1:0] dvd0, dvd1;
    logic [STEP_W-1:0] dsr0, dsr1;
    logic [QUO_W-1:0]  quo0, quo1;
    logic [STEP_W-1:0] rem0, rem1;
    logic              done0, done1;

    logic [U_W-1:0]    ux_reg, uy_reg;
    logic [PROD_W-1:0] prod0_reg, prod1_reg;

    assign div_start = (cmd.op == OP_DIV_IDX) || (cmd.op == OP_DIV_X) || (cmd.op == OP_DIV_Y);

    always_comb
    begin
        dvd0 = prod0_reg;
        dvd1 = prod1_reg;
        dsr0 = x_step_reg;
        dsr1 = x_step_reg;
        unique case (cmd.op)
            OP_DIV_IDX:
            begin
                dvd0 = PROD_W'(ux_reg[Q_W-1:0]);
                dvd1 = PROD_W'(uy_reg[Q_W-1:0]);
                dsr1 = y_step_reg;
            end
            OP_DIV_Y:
            begin
                dsr0 = y_step_reg;
            end
            default: ;
        endcase
    end

    bgi_div u_div0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dvd0),
        .divisor   (dsr0),
        .quotient  (quo0),
        .remainder (rem0),
        .done      (done0)
    );

    bgi_div u_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dvd1),
        .divisor   (dsr1),
        .quotient  (quo1),
        .remainder (rem1),
        .done      (done1)
    );

    // Range checks before and after the index division
    logic pre_ok_x, pre_ok_y, idx_ok_x, idx_ok_y;

    always_comb
    begin
        pre_ok_x = !ux_reg[U_W-1] && (x_step_reg != '0) && (x_cnt_eff >= XCW'(2));
        pre_ok_y = !uy_reg[U_W-1] && (y_step_reg != '0) && (y_cnt_eff >= YCW'(2));
        idx_ok_x = ({1'b0, quo0} + 33'd2) <= 33'(x_cnt_eff);
        idx_ok_y = ({1'b0, quo1} + 33'd2) <= 33'(y_cnt_eff);
    end

    assign status.pre_ok   = pre_ok_x && pre_ok_y;
    assign status.idx_ok   = idx_ok_x && idx_ok_y;
    assign status.div_done = done0 && done1;

    // Working registers
    logic [STEP_W-1:0] rx_reg, ry_reg;
    logic [Q_W-1:0]    corner_reg [NUM_CORNERS];
    logic [Q_W-1:0]    dabs0_reg, dabs1_reg;
    logic              dneg0_reg, dneg1_reg;
    logic [Q_W-1:0]    v0_reg, v1_reg;

    // Differences of the endpoints
    logic [U_W-1:0] diff0, diff1, dmag0, dmag1;
    logic [Q_W-1:0] da0, db0;

    always_comb
    begin
        if (cmd.op == OP_DIFF_Y)
        begin
            da0 = v0_reg;
            db0 = v1_reg;
        end
        else
        begin
            da0 = corner_reg[0];
            db0 = corner_reg[1];
        end
        diff0 = {db0[Q_W-1], db0} - {da0[Q_W-1], da0};
        diff1 = {corner_reg[3][Q_W-1], corner_reg[3]} - {corner_reg[2][Q_W-1], corner_reg[2]};
        dmag0 = diff0[U_W-1] ? (U_W'(0) - diff0) : diff0;
        dmag1 = diff1[U_W-1] ? (U_W'(0) - diff1) : diff1;
    end

    // Magnitude times remainder
    logic [STEP_W-1:0] r0_sel;
    logic [PROD_W-1:0] mul0, mul1;

    assign r0_sel = (cmd.op == OP_MUL_Y) ? ry_reg : rx_reg;
    assign mul0   = PROD_W'(dabs0_reg) * PROD_W'(r0_sel);
    assign mul1   = PROD_W'(dabs1_reg) * PROD_W'(rx_reg);

    // Base plus floored quotient; negative deltas round the magnitude up
    logic [U_W-1:0]    qmag0, qmag1;
    logic [LERP_W-1:0] q0, q1, sum0, sum1;
    logic [Q_W-1:0]    base0, sat0, sat1;

    always_comb
    begin
        base0 = (cmd.op == OP_LERP_Y) ? v0_reg : corner_reg[0];
        qmag0 = {1'b0, quo0} + U_W'(dneg0_reg && (rem0 != '0));
        qmag1 = {1'b0, quo1} + U_W'(dneg1_reg && (rem1 != '0));
        q0    = dneg0_reg ? (LERP_W'(0) - {1'b0, qmag0}) : {1'b0, qmag0};
        q1    = dneg1_reg ? (LERP_W'(0) - {1'b0, qmag1}) : {1'b0, qmag1};
        sum0  = {{2{base0[Q_W-1]}}, base0} + q0;
        sum1  = {{2{corner_reg[2][Q_W-1]}}, corner_reg[2]} + q1;
        if (sum0[LERP_W-1:Q_W-1] == '0 || sum0[LERP_W-1:Q_W-1] == '1)
            sat0 = sum0[Q_W-1:0];
        else
            sat0 = sum0[LERP_W-1] ? Q_MIN : Q_MAX;
        if (sum1[LERP_W-1:Q_W-1] == '0 || sum1[LERP_W-1:Q_W-1] == '1)
            sat1 = sum1[Q_W-1:0];
        else
            sat1 = sum1[LERP_W-1] ? Q_MIN : Q_MAX;
    end

    // Datapath register updates
    always_ff @(posedge clk)
    begin
        if (cmd.cap_en)
            corner_reg[cmd.cap_corner] <= rd_data_reg;

        unique case (cmd.op)
            OP_LOAD:
            begin
                ux_reg <= {x_value[Q_W-1], x_value} + {x_off_reg[Q_W-1], x_off_reg};
                uy_reg <= {y_value[Q_W-1], y_value} + {y_off_reg[Q_W-1], y_off_reg};
            end
            OP_IDX_LATCH:
            begin
                ix_reg <= quo0[XW-1:0];
                iy_reg <= quo1[YW-1:0];
                rx_reg <= rem0;
                ry_reg <= rem1;
            end
            OP_DIFF_X, OP_DIFF_Y:
            begin
                dabs0_reg <= dmag0[Q_W-1:0];
                dneg0_reg <= diff0[U_W-1];
                dabs1_reg <= dmag1[Q_W-1:0];
                dneg1_reg <= diff1[U_W-1];
            end
            OP_MUL_X, OP_MUL_Y:
            begin
                prod0_reg <= mul0;
                prod1_reg <= mul1;
            end
            OP_LERP_X:
            begin
                v0_reg <= sat0;
                v1_reg <= sat1;
            end
            OP_LERP_Y:
            begin
                v0_reg <= sat0;
            end
            OP_OUT_VAL:
            begin
                result_value <= v0_reg;
                out_of_range <= 1'b0;
            end
            OP_OUT_OOR:
            begin
                result_value <= '0;
                out_of_range <= 1'b1;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/bgi_ctrl.sv =====
`default_nettype none

module bgi_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_query,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire bgi_pkg::dp_status_t   status,
    output bgi_pkg::dp_cmd_t           cmd
);
    import bgi_pkg::*;

    ctl_state_t             state_reg, state_next;
    logic [FETCH_CNT_W-1:0] fetch_cnt_reg, fetch_cnt_next;
    logic                   out_valid_reg, out_valid_next;

    logic in_fire;
    logic out_free;
    logic fetch_last;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign fetch_last = (fetch_cnt_reg == FETCH_CNT_W'(NUM_CORNERS));
    assign out_valid  = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_fire && in_query == OPER_QUERY) state_next = ST_CHECK;
            ST_CHECK:    state_next = status.pre_ok ? ST_WAIT_IDX : ST_OUT_OOR;
            ST_WAIT_IDX: if (status.div_done) state_next = ST_IDX;
            ST_IDX:      state_next = status.idx_ok ? ST_FETCH : ST_OUT_OOR;
            ST_FETCH:    if (fetch_last) state_next = ST_DIFF_X;
            ST_DIFF_X:   state_next = ST_MUL_X;
            ST_MUL_X:    state_next = ST_START_X;
            ST_START_X:  state_next = ST_WAIT_X;
            ST_WAIT_X:   if (status.div_done) state_next = ST_LERP_X;
            ST_LERP_X:   state_next = ST_DIFF_Y;
            ST_DIFF_Y:   state_next = ST_MUL_Y;
            ST_MUL_Y:    state_next = ST_START_Y;
            ST_START_Y:  state_next = ST_WAIT_Y;
            ST_WAIT_Y:   if (status.div_done) state_next = ST_LERP_Y;
            ST_LERP_Y:   state_next = ST_OUT_VAL;
            ST_OUT_VAL:  if (out_free) state_next = ST_IDLE;
            ST_OUT_OOR:  if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd            = '0;
        cmd.op         = OP_NONE;
        fetch_cnt_next = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    cmd.op = (in_query == OPER_QUERY) ? OP_LOAD : OP_WRITE;
            end
            ST_CHECK:   if (status.pre_ok) cmd.op = OP_DIV_IDX;
            ST_IDX:     if (status.idx_ok) cmd.op = OP_IDX_LATCH;
            ST_FETCH:
            begin
                // read corner n while capturing corner n-1
                cmd.rd_en      = !fetch_last;
                cmd.rd_corner  = fetch_cnt_reg[CORNER_W-1:0];
                cmd.cap_en     = (fetch_cnt_reg != '0);
                cmd.cap_corner = CORNER_W'(fetch_cnt_reg - FETCH_CNT_W'(1));
                if (!fetch_last)
                    fetch_cnt_next = fetch_cnt_reg + FETCH_CNT_W'(1);
            end
            ST_DIFF_X:  cmd.op = OP_DIFF_X;
            ST_MUL_X:   cmd.op = OP_MUL_X;
            ST_START_X: cmd.op = OP_DIV_X;
            ST_LERP_X:  cmd.op = OP_LERP_X;
            ST_DIFF_Y:  cmd.op = OP_DIFF_Y;
            ST_MUL_Y:   cmd.op = OP_MUL_Y;
            ST_START_Y: cmd.op = OP_DIV_Y;
            ST_LERP_Y:  cmd.op = OP_LERP_Y;
            ST_OUT_VAL:
            begin
                if (out_free)
                begin
                    cmd.op         = OP_OUT_VAL;
                    out_valid_next = 1'b1;
                end
            end
            ST_OUT_OOR:
            begin
                if (out_free)
                begin
                    cmd.op         = OP_OUT_OOR;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fetch_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fetch_cnt_reg <= fetch_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Divider completion lands only in a wait state
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |->
            (state_reg == ST_WAIT_IDX || state_reg == ST_WAIT_X || state_reg == ST_WAIT_Y))
        else $error("divider finished outside a wait state");

endmodule

`default_nettype wire

// ===== sv/bilinear_grid_interpolator_top.sv =====
`default_nettype none

// Bilinear interpolation over a Q16.16 calibration grid.
// item channel: operation 0 stores entry_value at (col_index, row_index) and
//   gives no result word; operation 1 queries the point (x_value, y_value).
// result channel: one word per query, result_value and out_of_range.
// Config port: cfg_wr_en / cfg_index / cfg_data, to be written only while idle;
// the block does not enforce this. Grid writes are accepted back to back.
// A query in range gives its result word after three passes of a radix-2
// divider (cell index, row interpolation, column interpolation) and the
// four corner reads from the grid RAM; no new item is taken until the
// block is back in idle after the result word is registered.
// A point failing the sign, step or count check answers straight after the
// check; one whose cell index is too high answers after the index division.
// The result sits in an output register: a new item is accepted while it
// waits, and a later query holds in its final state until the receiver takes the waiting result.
// Reset clears control state and loads the register defaults (offsets 0,
// steps 1.0, counts 32). The grid is not cleared; entries must be written
// before they are read.
module bilinear_grid_interpolator_top #(
    parameter int unsigned MAX_X_POINTS = 32,
    parameter int unsigned MAX_Y_POINTS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    bgi_item_if.sink                            item,
    bgi_result_if.source                        result,
    input  wire logic                           cfg_wr_en,
    input  wire logic [bgi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bgi_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bgi_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       ctl_in_ready;
    logic       ctl_out_valid;

    assign item.ready   = ctl_in_ready;
    assign result.valid = ctl_out_valid;

    bgi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_query  (item.operation),
        .in_ready  (ctl_in_ready),
        .out_valid (ctl_out_valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    bgi_datapath #(
        .MAX_X_POINTS (MAX_X_POINTS),
        .MAX_Y_POINTS (MAX_Y_POINTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .x_value      (item.x_value),
        .y_value      (item.y_value),
        .col_index    (item.col_index),
        .row_index    (item.row_index),
        .entry_value  (item.entry_value),
        .result_value (result.result_value),
        .out_of_range (result.out_of_range)
    );

endmodule

`default_nettype wire

// ===== test/bilinear_grid_interpolator_top_tb.sv =====
`timescale 1ns / 1ps

module bilinear_grid_interpolator_top_tb;
    import bgi_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 3;
    localparam int MAX_GAP       = 11;
    localparam int SETTLE_CYCLES = 130;   // longest query latency plus margin
    localparam int MAX_X_POINTS  = 32;
    localparam int MAX_Y_POINTS  = 32;
    localparam int GRID_DEPTH    = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int QUERY_PCT     = 55;

    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct {
        logic                  operation;
        logic signed [Q_W-1:0] x_value;
        logic signed [Q_W-1:0] y_value;
        logic [IDX_IN_W-1:0]   col_index;
        logic [IDX_IN_W-1:0]   row_index;
        logic signed [Q_W-1:0] entry_value;
    } item_word_t;

    typedef struct {
        logic signed [Q_W-1:0] value;
        logic                  oor;
    } answer_t;

    typedef struct {
        longint offset;
        longint step;
        longint count;
    } axis_cfg_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bgi_item_if   item_ch ();
    bgi_result_if result_ch ();

    bilinear_grid_interpolator_top #(
        .MAX_X_POINTS (MAX_X_POINTS),
        .MAX_Y_POINTS (MAX_Y_POINTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the block: axis registers and grid contents
    axis_cfg_t             x_axis;
    axis_cfg_t             y_axis;
    logic signed [Q_W-1:0] grid_model [GRID_DEPTH];
    bit                    grid_planned [GRID_DEPTH];  // written by some queued word

    item_word_t words_to_send [$];
    answer_t    interp_answers [$];
    item_word_t drive_word;
    int         error_count = 0;
    int         send_gap;
    int         take_gap;
    bit         send_calm = 1'b0;
    bit         take_calm = 1'b0;

    always #(CLK_HALF) clk = ~clk;

    // Cell index and remainder on one axis; 0 when the point is off the grid
    function automatic bit axis_locate(input logic signed [Q_W-1:0] coord,
                                       input axis_cfg_t a, input longint max_pts,
                                       output longint cell_idx, output longint rem);
        longint u;
        longint cnt;
        cell_idx = 0;
        rem      = 0;
        u        = longint'(coord) + a.offset;
        cnt      = (a.count > max_pts) ? max_pts : a.count;
        if (u < 0 || a.step == 0 || cnt < 2)
            return 1'b0;
        cell_idx = u / a.step;
        if (cell_idx > cnt - 2)
            return 1'b0;
        rem = u - cell_idx * a.step;
        return 1'b1;
    endfunction

    // a + floor((b - a) * r / step)
    function automatic longint lerp_floor(longint a, longint b, longint r, longint step);
        longint p;
        p = (b - a) * r;
        if (p >= 0)
            return a + p / step;
        return a - (-p + step - 1) / step;
    endfunction

    function automatic longint grid_at(longint col, longint row);
        return longint'(grid_model[row * MAX_X_POINTS + col]);
    endfunction

    // Update the grid copy on a write, queue the answer on a query
    function automatic void track_word(item_word_t w);
        longint  cx, rx, cy, ry, v0, v1, v;
        answer_t ans;
        if (w.operation == OPER_WRITE)
        begin
            grid_model[int'(w.row_index) * MAX_X_POINTS + int'(w.col_index)] = w.entry_value;
            return;
        end
        if (!axis_locate(w.x_value, x_axis, MAX_X_POINTS, cx, rx) ||
            !axis_locate(w.y_value, y_axis, MAX_Y_POINTS, cy, ry))
        begin
            ans.value = '0;
            ans.oor   = 1'b1;
        end
        else
        begin
            v0 = lerp_floor(grid_at(cx, cy), grid_at(cx + 1, cy), rx, x_axis.step);
            v1 = lerp_floor(grid_at(cx, cy + 1), grid_at(cx + 1, cy + 1), rx, x_axis.step);
            v  = lerp_floor(v0, v1, ry, y_axis.step);
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            if (v < -64'sd2147483648)
                v = -64'sd2147483648;
            ans.value = v[Q_W-1:0];
            ans.oor   = 1'b0;
        end
        interp_answers.push_back(ans);
    endfunction

    function automatic logic signed [Q_W-1:0] pick_entry();
        case ($urandom_range(0, 7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    // Coordinate aimed mostly inside the grid, with edges and misses mixed in
    function automatic logic signed [Q_W-1:0] pick_coord(axis_cfg_t a, longint max_pts);
        longint cnt, cell_idx, rem, u, c;
        int     mode;
        cnt  = (a.count > max_pts) ? max_pts : a.count;
        mode = $urandom_range(0, 99);
        if (mode < 70 && cnt >= 2 && a.step > 0)
        begin
            cell_idx = longint'($urandom_range(0, cnt - 2));
            if ($urandom_range(0, 9) == 0)
                cell_idx = cnt - 1 + longint'($urandom_range(0, 2));
            case ($urandom_range(0, 3))
                0:       rem = 0;
                1:       rem = a.step - 1;
                default: rem = longint'($urandom) % a.step;
            endcase
            u = cell_idx * a.step + rem;
        end
        else if (mode < 82)
        begin
            if ($urandom_range(0, 1) == 0)
                u = -longint'($urandom_range(1, 32'h20000));
            else
                u = -longint'($urandom) - 1;
        end
        else
            return $urandom;
        c = u - a.offset;
        if (c < -64'sd2147483648 || c > 64'sd2147483647)
            return $urandom;
        return c[Q_W-1:0];
    endfunction

    function automatic void push_write(int col, int row, logic signed [Q_W-1:0] val);
        item_word_t w;
        w.operation   = OPER_WRITE;
        w.x_value     = $urandom;
        w.y_value     = $urandom;
        w.col_index   = col[IDX_IN_W-1:0];
        w.row_index   = row[IDX_IN_W-1:0];
        w.entry_value = val;
        grid_planned[row * MAX_X_POINTS + col] = 1'b1;
        words_to_send.push_back(w);
    endfunction

    // Queue a query, writing any corner it reads that holds no value yet
    function automatic void push_query(logic signed [Q_W-1:0] x, logic signed [Q_W-1:0] y);
        item_word_t w;
        longint     cx, rx, cy, ry;
        if (axis_locate(x, x_axis, MAX_X_POINTS, cx, rx) &&
            axis_locate(y, y_axis, MAX_Y_POINTS, cy, ry))
        begin
            for (int dy = 0; dy < 2; dy++)
                for (int dx = 0; dx < 2; dx++)
                    if (!grid_planned[(cy + dy) * MAX_X_POINTS + cx + dx])
                        push_write(int'(cx) + dx, int'(cy) + dy, pick_entry());
        end
        w.operation   = OPER_QUERY;
        w.x_value     = x;
        w.y_value     = y;
        w.col_index   = $urandom;
        w.row_index   = $urandom;
        w.entry_value = $urandom;
        words_to_send.push_back(w);
    endfunction

    function automatic longint pick_offset();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return longint'($urandom_range(0, 32'h200000)) - 32'h100000;
            2:       return -longint'($urandom_range(0, 32'h40000));
            default: return longint'($signed($urandom));
        endcase
    endfunction

    function automatic longint pick_step();
        longint s;
        case ($urandom_range(0, 3))
            0:       s = $urandom_range(1, 16);
            1:       s = 65536;
            2:       s = $urandom_range(1, 32'h100000);
            default: s = $urandom & 32'h7FFF_FFFF;
        endcase
        return (s == 0) ? 1 : s;
    endfunction

    function automatic longint pick_count();
        case ($urandom_range(0, 5))
            0:       return 2;
            1:       return 32;
            default: return $urandom_range(2, 32);
        endcase
    endfunction

    // One register write; the shadow follows the same masking as the block
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_X_OFFSET: x_axis.offset = longint'($signed(data));
            CFG_X_STEP:   x_axis.step   = longint'(data[STEP_W-1:0]);
            CFG_X_COUNT:  x_axis.count  = longint'(data[CNT_W-1:0]);
            CFG_Y_OFFSET: y_axis.offset = longint'($signed(data));
            CFG_Y_STEP:   y_axis.step   = longint'(data[STEP_W-1:0]);
            CFG_Y_COUNT:  y_axis.count  = longint'(data[CNT_W-1:0]);
            default: ;
        endcase
    endtask

    // Write all six registers, and the two spare indexes if asked; unused upper bits of steps and counts are random
    task automatic load_axes(input longint xo, input longint xs, input longint xc,
                             input longint yo, input longint ys, input longint yc,
                             input bit spare);
        write_reg(CFG_X_OFFSET, xo[Q_W-1:0]);
        write_reg(CFG_X_STEP,   {1'($urandom), xs[STEP_W-1:0]});
        write_reg(CFG_X_COUNT,  {26'($urandom), xc[CNT_W-1:0]});
        write_reg(CFG_Y_OFFSET, yo[Q_W-1:0]);
        write_reg(CFG_Y_STEP,   {1'($urandom), ys[STEP_W-1:0]});
        write_reg(CFG_Y_COUNT,  {26'($urandom), yc[CNT_W-1:0]});
        if (spare)
        begin
            write_reg(CFG_SPARE_A, $urandom);
            write_reg(CFG_SPARE_B, $urandom);
        end
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every word went out and every answer came back
    task automatic drain_block();
        do
            @(negedge clk);
        while (words_to_send.size() != 0 || item_ch.valid || interp_answers.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int n_words);
        for (int i = 0; i < n_words; i++)
        begin
            if ($urandom_range(0, 99) < QUERY_PCT)
                push_query(pick_coord(x_axis, MAX_X_POINTS), pick_coord(y_axis, MAX_Y_POINTS));
            else
                push_write($urandom_range(0, MAX_X_POINTS - 1), $urandom_range(0, MAX_Y_POINTS - 1),
                           pick_entry());
        end
        drain_block();
    endtask

    // Input driver: random gap after each accepted word, calm stretches with none
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
                track_word(drive_word);
            if (!item_ch.valid || item_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_ch.valid <= 1'b0;
                end
                else if (words_to_send.size() > 0)
                begin
                    drive_word = words_to_send.pop_front();
                    item_ch.valid       <= 1'b1;
                    item_ch.operation   <= drive_word.operation;
                    item_ch.x_value     <= drive_word.x_value;
                    item_ch.y_value     <= drive_word.y_value;
                    item_ch.col_index   <= drive_word.col_index;
                    item_ch.row_index   <= drive_word.row_index;
                    item_ch.entry_value <= drive_word.entry_value;
                    if ($urandom_range(0, 39) == 0)
                        send_calm = !send_calm;
                    send_gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: stall counted while a word waits, then compare
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            take_gap = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (interp_answers.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result word expected none actual value %h oor %b", $time,
                             result_ch.result_value, result_ch.out_of_range);
                end
                else
                begin
                    answer_t want;
                    want = interp_answers.pop_front();
                    if (result_ch.result_value !== want.value)
                    begin
                        error_count++;
                        $display("%0t: result_value expected %h actual %h", $time,
                                 want.value, result_ch.result_value);
                    end
                    if (result_ch.out_of_range !== want.oor)
                    begin
                        error_count++;
                        $display("%0t: out_of_range expected %b actual %b", $time,
                                 want.oor, result_ch.out_of_range);
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    take_calm = !take_calm;
                take_gap = take_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            else if (take_gap > 0 && result_ch.valid)
                take_gap--;
            result_ch.ready <= (take_gap == 0);
        end
    end

    // Stimulus sequence
    initial
    begin
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        item_ch.valid         = 1'b0;
        item_ch.operation     = OPER_WRITE;
        item_ch.x_value       = '0;
        item_ch.y_value       = '0;
        item_ch.col_index     = '0;
        item_ch.row_index     = '0;
        item_ch.entry_value   = '0;
        result_ch.ready       = 1'b0;
        x_axis                = '{0, 65536, 32};
        y_axis                = '{0, 65536, 32};
        for (int i = 0; i < GRID_DEPTH; i++)
        begin
            grid_model[i]   = '0;
            grid_planned[i] = 1'b0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset-value settings, extreme corners and edge points
        load_axes(0, 65536, 32, 0, 65536, 32, 1'b0);
        push_write(0, 0, Q_MAX);
        push_write(1, 0, Q_MIN);
        push_write(0, 1, Q_MIN);
        push_write(1, 1, Q_MAX);
        push_write(30, 30, '0);
        push_write(31, 30, 32'h0001_0000);
        push_write(30, 31, 32'hFFFF_FFFF);
        push_write(31, 31, Q_MIN);
        push_query(32'h0000_0000, 32'h0000_0000);
        push_query(32'h0000_8000, 32'h0000_8000);
        push_query(32'h0000_FFFF, 32'h0000_FFFF);
        push_query(32'h001E_1234, 32'h001E_FFFF);
        push_query(32'h001F_0000, 32'h0000_0000);   // x cell has no upper neighbor
        push_query(32'h0000_0000, 32'h001F_0000);   // same on y
        push_query(32'hFFFF_FFFF, 32'h0000_0000);   // negative x
        push_query(32'h0000_0000, Q_MIN);           // negative y
        push_query(Q_MAX, Q_MAX);
        push_query(32'h0001_0000, 32'h0001_0000);
        drain_block();
        run_random(300);

        // Smallest step and count
        load_axes(0, 1, 2, 0, 1, 2, 1'b0);
        run_random(120);

        // Largest step, offsets at both extremes
        load_axes(-64'sd2147483648, 32'h7FFF_FFFF, 3, 64'sd2147483647, 32'h7FFF_FFFF, 2, 1'b0);
        run_random(150);

        // Counts above the grid size
        load_axes(-32'sh8000, 4096, 63, 32'sh12345, 100000, 33, 1'b0);
        run_random(200);

        // Zero step on x, zero count on y, spare indexes written
        load_axes(0, 0, 32, 0, 65536, 0, 1'b1);
        run_random(40);

        // Count of one on x, zero step on y
        load_axes(0, 65536, 1, 0, 0, 32, 1'b0);
        run_random(30);

        // Random settings
        for (int p = 0; p < 5; p++)
        begin
            load_axes(pick_offset(), pick_step(), pick_count(),
                      pick_offset(), pick_step(), pick_count(), 1'b0);
            run_random(162);
        end

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(20_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/bgi_pkg.sv
sv/bgi_if.sv
sv/bgi_div.sv
sv/bgi_datapath.sv
sv/bgi_ctrl.sv
sv/bilinear_grid_interpolator_top.sv
test/bilinear_grid_interpolator_top_tb.sv
